FILE: rtl/aald_pkg.sv
// Shared types, codes and helpers for the Annex B length deframer.
// No dependencies; used by aald_front, aald_back and the top level.
package aald_pkg;

	localparam int MAX_SIZE_BYTES = 8;
	localparam int CNT_W          = $clog2(MAX_SIZE_BYTES + 1);
	localparam int SIZE_W         = 32;

	typedef enum logic [1:0] {
		KIND_UNIT,
		KIND_FRAME,
		KIND_OBU,
		KIND_PAYLOAD
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_SIZE,
		ERR_OVERRUN
	} err_t;

	// classified input beat
	typedef struct packed {
		logic [7:0] data;
		logic       more;
		logic [6:0] pay;
		logic       pay_hi;
		logic       pay_nz;
	} cls_t;

	// front to back handoff
	typedef struct packed {
		logic valid;
		cls_t beat;
	} fe_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data;
		logic              size_done;
		logic [SIZE_W-1:0] size_value;
		logic              obu_begin;
		logic              obu_end;
		logic              frame_end;
		logic              unit_end;
		err_t              err;
	} res_t;

	// place a LEB128 payload group at its bit position; groups past the fifth add nothing
	function automatic logic [SIZE_W-1:0] leb_place(logic [6:0] pay, logic [CNT_W-1:0] idx);
		logic [SIZE_W-1:0] r;
		case (idx)
			CNT_W'(0): r = {25'b0, pay};
			CNT_W'(1): r = {18'b0, pay, 7'b0};
			CNT_W'(2): r = {11'b0, pay, 14'b0};
			CNT_W'(3): r = {4'b0, pay, 21'b0};
			CNT_W'(4): r = {pay[3:0], 28'b0};
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/aald_front.sv
// Front end: classifies incoming stream bytes and holds them in a two-entry queue.
// Depends on aald_pkg.
module aald_front import aald_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] stream_byte,
	output fe_t        fe,
	input  logic       fe_pop
);

	cls_t       q_mem [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cls_t       cls;
	logic       wr;
	logic       rd;

	always_comb begin
		cls.data   = stream_byte;
		cls.more   = stream_byte[7];
		cls.pay    = stream_byte[6:0];
		cls.pay_hi = stream_byte[6:4] != 3'b0;
		cls.pay_nz = stream_byte[6:0] != 7'b0;
	end

	assign full     = cnt_q == 2'd2;
	assign wr       = push && !full;
	assign rd       = fe_pop && (cnt_q != 2'd0);
	assign fe.valid = cnt_q != 2'd0;
	assign fe.beat  = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_mem[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

FILE: rtl/aald_back.sv
// Back end: nested LEB128 size tracking, byte tagging and a two-entry result queue.
// Depends on aald_pkg.
module aald_back import aald_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  fe_t  fe,
	output logic fe_pop,
	output logic empty,
	input  logic pop,
	output res_t head
);

	kind_t             phase_q, phase_d;
	logic [SIZE_W-1:0] accum_q, accum_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [SIZE_W-1:0] unit_q, unit_d;
	logic [SIZE_W-1:0] frame_q, frame_d;
	logic [SIZE_W-1:0] obu_q, obu_d;

	cls_t              b;
	logic [CNT_W-1:0]  idx_inc;
	logic              e_size;
	logic [SIZE_W-1:0] v;
	logic              v_zero;
	logic [SIZE_W-1:0] unit_left;
	logic [SIZE_W-1:0] frame_left;
	res_t              res;

	res_t              oq_mem [2];
	logic              owp_q;
	logic              orp_q;
	logic [1:0]        ocnt_q;
	logic              fire;
	logic              rd;

	assign b       = fe.beat;
	assign idx_inc = cnt_q + CNT_W'(1);
	assign e_size  = (cnt_q >= CNT_W'(MAX_SIZE_BYTES))
		|| (cnt_q == CNT_W'(4) && b.pay_hi)
		|| (cnt_q > CNT_W'(4) && b.pay_nz)
		|| (b.more && idx_inc >= CNT_W'(MAX_SIZE_BYTES));
	assign v          = accum_q | leb_place(b.pay, cnt_q);
	assign v_zero     = v == '0;
	// rem - 1 - v as rem + ~v
	assign unit_left  = unit_q + ~v;
	assign frame_left = frame_q + ~v;

	// result of the current beat
	always_comb begin
		res      = '0;
		res.kind = phase_q;
		res.data = b.data;
		res.err  = ERR_NONE;
		case (phase_q)
			KIND_UNIT: begin
				if (e_size) begin
					res.err = ERR_SIZE;
				end else if (!b.more) begin
					res.size_done  = 1'b1;
					res.size_value = v;
					res.unit_end   = v_zero;
				end
			end
			KIND_FRAME: begin
				if (unit_q == '0) begin
					res.err = ERR_OVERRUN;
				end else if (e_size) begin
					res.err = ERR_SIZE;
				end else if (b.more) begin
					if (unit_q[SIZE_W-1:1] == '0) begin
						res.err = ERR_OVERRUN;
					end
				end else if (v >= unit_q) begin
					res.err = ERR_OVERRUN;
				end else begin
					res.size_done  = 1'b1;
					res.size_value = v;
					res.frame_end  = v_zero;
					res.unit_end   = v_zero && (unit_left == '0);
				end
			end
			KIND_OBU: begin
				if (frame_q == '0) begin
					res.err = ERR_OVERRUN;
				end else if (e_size) begin
					res.err = ERR_SIZE;
				end else if (b.more) begin
					if (frame_q[SIZE_W-1:1] == '0) begin
						res.err = ERR_OVERRUN;
					end
				end else if (v >= frame_q) begin
					res.err = ERR_OVERRUN;
				end else begin
					res.size_done  = 1'b1;
					res.size_value = v;
					res.obu_begin  = 1'b1;
					res.obu_end    = v_zero;
					res.frame_end  = v_zero && (frame_left == '0);
					res.unit_end   = v_zero && (frame_left == '0) && (unit_q == '0);
				end
			end
			KIND_PAYLOAD: begin
				if (obu_q == '0) begin
					res.err = ERR_OVERRUN;
				end else if (obu_q == SIZE_W'(1)) begin
					res.obu_end   = 1'b1;
					res.frame_end = frame_q == '0;
					res.unit_end  = (frame_q == '0) && (unit_q == '0);
				end
			end
			default: begin
				res.err = ERR_NONE;
			end
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		cnt_d   = cnt_q;
		unit_d  = unit_q;
		frame_d = frame_q;
		obu_d   = obu_q;
		case (phase_q)
			KIND_UNIT: begin
				if (b.more) begin
					accum_d = v;
					cnt_d   = idx_inc;
				end else begin
					accum_d = '0;
					cnt_d   = '0;
					unit_d  = v;
					phase_d = v_zero ? KIND_UNIT : KIND_FRAME;
				end
			end
			KIND_FRAME: begin
				if (b.more) begin
					accum_d = v;
					cnt_d   = idx_inc;
					unit_d  = unit_q - SIZE_W'(1);
				end else begin
					accum_d = '0;
					cnt_d   = '0;
					unit_d  = unit_left;
					frame_d = v;
					if (!v_zero) begin
						phase_d = KIND_OBU;
					end else begin
						phase_d = (unit_left == '0) ? KIND_UNIT : KIND_FRAME;
					end
				end
			end
			KIND_OBU: begin
				if (b.more) begin
					accum_d = v;
					cnt_d   = idx_inc;
					frame_d = frame_q - SIZE_W'(1);
				end else begin
					accum_d = '0;
					cnt_d   = '0;
					frame_d = frame_left;
					obu_d   = v;
					if (!v_zero) begin
						phase_d = KIND_PAYLOAD;
					end else if (frame_left == '0) begin
						phase_d = (unit_q == '0) ? KIND_UNIT : KIND_FRAME;
					end
				end
			end
			KIND_PAYLOAD: begin
				obu_d = obu_q - SIZE_W'(1);
				if (obu_q == SIZE_W'(1)) begin
					if (frame_q != '0) begin
						phase_d = KIND_OBU;
					end else begin
						phase_d = (unit_q == '0) ? KIND_UNIT : KIND_FRAME;
					end
				end
			end
			default: begin
				phase_d = KIND_UNIT;
			end
		endcase
		// any error resynchronizes on a fresh unit size
		if (res.err != ERR_NONE) begin
			phase_d = KIND_UNIT;
			accum_d = '0;
			cnt_d   = '0;
			unit_d  = '0;
			frame_d = '0;
			obu_d   = '0;
		end
	end

	assign fire   = fe.valid && (ocnt_q != 2'd2);
	assign fe_pop = fire;
	assign rd     = pop && (ocnt_q != 2'd0);
	assign empty  = ocnt_q == 2'd0;
	assign head   = oq_mem[orp_q];

	always_ff @(posedge clk) begin
		if (fire) begin
			oq_mem[owp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= KIND_UNIT;
			accum_q <= '0;
			cnt_q   <= '0;
			unit_q  <= '0;
			frame_q <= '0;
			obu_q   <= '0;
			owp_q   <= 1'b0;
			orp_q   <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				accum_q <= accum_d;
				cnt_q   <= cnt_d;
				unit_q  <= unit_d;
				frame_q <= frame_d;
				obu_q   <= obu_d;
				owp_q   <= ~owp_q;
			end
			if (rd) begin
				orp_q <= ~orp_q;
			end
			ocnt_q <= ocnt_q + {1'b0, fire} - {1'b0, rd};
		end
	end

endmodule

FILE: rtl/av1_annexb_length_deframer_unit.sv
// Annex B length deframer top level: classifier front end, size tracking back end.
// Depends on aald_pkg, aald_front and aald_back.
//
// Takes an AV1 Annex B stream one byte per push and returns one tagged beat per
// byte: its role (unit size, frame size, obu size or obu payload), completed
// LEB128 sizes, and obu begin/end, frame end and unit end marks. Size fields
// longer than eight bytes or wider than 32 bits give error 1; an inner size
// that overruns its parent gives error 2, after which the next byte starts a
// new temporal unit size. Throughput is one byte per clock while neither queue
// is full; each byte's result passes through the front queue and then the result
// queue before it can be popped. Both sides are two-entry queues.
module av1_annexb_length_deframer_unit import aald_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        stream_byte,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        byte_kind,
	output logic [7:0]        passed_byte,
	output logic              size_done,
	output logic [SIZE_W-1:0] size_value,
	output logic              obu_begin,
	output logic              obu_end,
	output logic              frame_end,
	output logic              unit_end,
	output logic [1:0]        error_code
);

	fe_t  fe;
	logic fe_pop;
	res_t head;

	aald_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.stream_byte (stream_byte),
		.fe          (fe),
		.fe_pop      (fe_pop)
	);

	aald_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fe     (fe),
		.fe_pop (fe_pop),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign byte_kind   = head.kind;
	assign passed_byte = head.data;
	assign size_done   = head.size_done;
	assign size_value  = head.size_value;
	assign obu_begin   = head.obu_begin;
	assign obu_end     = head.obu_end;
	assign frame_end   = head.frame_end;
	assign unit_end    = head.unit_end;
	assign error_code  = head.err;

endmodule

FILE: test/tb.sv
// Self-checking bench for av1_annexb_length_deframer_unit: byte tagging, LEB128 sizes, marks, errors.
// Depends on aald_pkg and the deframer RTL; a tracker class predicts each result beat.
`timescale 1ns / 100ps

module tb;
	import aald_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef logic [7:0] byte_q_t[$];
	typedef enum {LEB_MORE, LEB_DONE, LEB_BAD} leb_t;

	// Tracks unit/frame/obu nesting and queues the tagged beat due for each byte.
	class annexb_tracker;
		res_t        due_beats[$];
		kind_t       phase;
		logic [31:0] accum;
		int unsigned size_idx;
		logic [31:0] unit_left;
		logic [31:0] frame_left;
		logic [31:0] obu_left;
		int unsigned fails;

		function new();
			clear_state();
			fails = 0;
		endfunction

		function void clear_state();
			phase      = KIND_UNIT;
			accum      = '0;
			size_idx   = 0;
			unit_left  = '0;
			frame_left = '0;
			obu_left   = '0;
		endfunction

		function leb_t leb_step(logic [7:0] b);
			if (size_idx >= MAX_SIZE_BYTES) return LEB_BAD;
			if (size_idx == 4 && b[6:4] != 3'd0) return LEB_BAD;
			if (size_idx > 4 && b[6:0] != 7'd0) return LEB_BAD;
			if (b[7] && size_idx + 1 >= MAX_SIZE_BYTES) return LEB_BAD;
			if (size_idx <= 4) accum |= {25'd0, b[6:0]} << (7 * size_idx);
			if (b[7]) begin
				size_idx++;
				return LEB_MORE;
			end
			size_idx = 0;
			return LEB_DONE;
		endfunction

		function res_t close_frame(res_t r);
			r.frame_end = 1'b1;
			if (unit_left == 0) begin
				r.unit_end = 1'b1;
				phase = KIND_UNIT;
			end else begin
				phase = KIND_FRAME;
			end
			return r;
		endfunction

		function void tag_byte(logic [7:0] b);
			res_t        r;
			leb_t        st;
			logic [31:0] v;
			logic [31:0] left;
			err_t        e;
			kind_t       due_kind;
			due_kind = phase;
			r      = '0;
			r.kind = phase;
			r.data = b;
			e      = ERR_NONE;
			case (phase)
				KIND_UNIT: begin
					st = leb_step(b);
					if (st == LEB_BAD) e = ERR_SIZE;
					else if (st == LEB_DONE) begin
						v = accum;
						accum = '0;
						r.size_done  = 1'b1;
						r.size_value = v;
						unit_left    = v;
						if (v == 0) r.unit_end = 1'b1;
						else phase = KIND_FRAME;
					end
				end
				KIND_FRAME: begin
					if (unit_left == 0) e = ERR_OVERRUN;
					else begin
						st = leb_step(b);
						if (st == LEB_BAD) e = ERR_SIZE;
						else if (st == LEB_MORE) begin
							if (unit_left <= 1) e = ERR_OVERRUN;
							else unit_left--;
						end else begin
							v = accum;
							accum = '0;
							left = unit_left - 1;
							if (v > left) e = ERR_OVERRUN;
							else begin
								r.size_done  = 1'b1;
								r.size_value = v;
								unit_left    = left - v;
								frame_left   = v;
								if (v == 0) r = close_frame(r);
								else phase = KIND_OBU;
							end
						end
					end
				end
				KIND_OBU: begin
					if (frame_left == 0) e = ERR_OVERRUN;
					else begin
						st = leb_step(b);
						if (st == LEB_BAD) e = ERR_SIZE;
						else if (st == LEB_MORE) begin
							if (frame_left <= 1) e = ERR_OVERRUN;
							else frame_left--;
						end else begin
							v = accum;
							accum = '0;
							left = frame_left - 1;
							if (v > left) e = ERR_OVERRUN;
							else begin
								r.size_done  = 1'b1;
								r.size_value = v;
								r.obu_begin  = 1'b1;
								frame_left   = left - v;
								obu_left     = v;
								if (v == 0) begin
									r.obu_end = 1'b1;
									if (frame_left == 0) r = close_frame(r);
								end else begin
									phase = KIND_PAYLOAD;
								end
							end
						end
					end
				end
				default: begin
					if (obu_left == 0) e = ERR_OVERRUN;
					else begin
						obu_left--;
						if (obu_left == 0) begin
							r.obu_end = 1'b1;
							if (frame_left == 0) r = close_frame(r);
							else phase = KIND_OBU;
						end
					end
				end
			endcase
			if (e != ERR_NONE) begin
				r      = '0;
				r.kind = due_kind;
				r.data = b;
				r.err  = e;
				clear_state();
			end
			due_beats.push_back(r);
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_beat(res_t got);
			res_t w;
			bit   ok;
			if (due_beats.size() == 0) begin
				$display("%0t: result beat with none due: byte %0h, kind %0d",
					$time, got.data, got.kind);
				fails++;
				return;
			end
			w  = due_beats.pop_front();
			ok = 1'b1;
			ok &= field_ok("byte_kind", w.kind, got.kind);
			ok &= field_ok("passed_byte", w.data, got.data);
			ok &= field_ok("size_done", w.size_done, got.size_done);
			ok &= field_ok("size_value", w.size_value, got.size_value);
			ok &= field_ok("obu_begin", w.obu_begin, got.obu_begin);
			ok &= field_ok("obu_end", w.obu_end, got.obu_end);
			ok &= field_ok("frame_end", w.frame_end, got.frame_end);
			ok &= field_ok("unit_end", w.unit_end, got.unit_end);
			ok &= field_ok("error_code", w.err, got.err);
			if (!ok) fails++;
		endfunction

		function int pending();
			return due_beats.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [7:0]        stream_byte = 8'd0;
	logic              empty;
	logic              pop = 1'b0;
	logic [1:0]        byte_kind;
	logic [7:0]        passed_byte;
	logic              size_done;
	logic [SIZE_W-1:0] size_value;
	logic              obu_begin;
	logic              obu_end;
	logic              frame_end;
	logic              unit_end;
	logic [1:0]        error_code;

	annexb_tracker sb = new();
	int            bytes_sent = 0;
	bit            calm = 1'b0;

	av1_annexb_length_deframer_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.stream_byte(stream_byte),
		.empty      (empty),
		.pop        (pop),
		.byte_kind  (byte_kind),
		.passed_byte(passed_byte),
		.size_done  (size_done),
		.size_value (size_value),
		.obu_begin  (obu_begin),
		.obu_end    (obu_end),
		.frame_end  (frame_end),
		.unit_end   (unit_end),
		.error_code (error_code)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int leb_min(logic [31:0] v);
		int n;
		n = 1;
		while (n < 5 && (v >> (7 * n)) != 0) n++;
		return n;
	endfunction

	// mostly minimal encodings, sometimes zero-padded up to the limit
	function automatic int pick_len(logic [31:0] v);
		int m;
		m = leb_min(v);
		return ($urandom_range(7) == 0) ? int'($urandom_range(MAX_SIZE_BYTES, m)) : m;
	endfunction

	function automatic void put_leb(ref byte_q_t q, input logic [31:0] v, input int nb);
		logic [63:0] w;
		w = {32'd0, v};
		for (int i = 0; i < nb; i++) q.push_back({(i < nb - 1) ? 1'b1 : 1'b0, w[7*i +: 7]});
	endfunction

	// well-formed temporal unit with random frame/obu layout and payload
	function automatic void build_unit(ref byte_q_t q);
		byte_q_t body;
		byte_q_t fbody;
		int      nf;
		int      no;
		int      p;
		body.delete();
		nf = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 3));
		for (int f = 0; f < nf; f++) begin
			fbody.delete();
			no = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 3));
			for (int o = 0; o < no; o++) begin
				p = ($urandom_range(99) < 85) ? int'($urandom_range(0, 8))
					: int'($urandom_range(9, 150));
				put_leb(fbody, p, pick_len(p));
				repeat (p) fbody.push_back(8'($urandom));
			end
			put_leb(body, fbody.size(), pick_len(fbody.size()));
			foreach (fbody[i]) body.push_back(fbody[i]);
		end
		put_leb(q, body.size(), pick_len(body.size()));
		foreach (body[i]) q.push_back(body[i]);
	endfunction

	// push stays high after a beat so back-to-back bytes go out without a gap
	task automatic send_byte(input logic [7:0] b);
		if (!calm) begin
			while ($urandom_range(99) < 14) begin
				push <= 1'b0;
				stream_byte <= 8'($urandom);
				@(posedge clk);
			end
		end
		push <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.tag_byte(b);
		bytes_sent++;
	endtask

	task automatic send_seq(input byte_q_t s);
		foreach (s[i]) send_byte(s[i]);
	endtask

	// sender
	initial begin
		byte_q_t     q;
		int          sel;
		int          u;
		int          f;
		int          o;
		int          n;
		int          bad_at;
		bit          too_long;
		bit          paused;
		bit          more;
		logic [6:0]  pay;
		logic [31:0] v;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty unit, max unit size, too large, too long, overruns,
		// empty frame, empty obu, payload byte
		q = {8'h00,
			8'hff, 8'hff, 8'hff, 8'hff, 8'h0f,
			8'h80, 8'h80, 8'h80, 8'h80, 8'h10,
			8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
			8'h01, 8'h80,
			8'h02, 8'h05,
			8'h01, 8'h00,
			8'h02, 8'h01, 8'h00,
			8'h03, 8'h02, 8'h01, 8'ha5};
		send_seq(q);

		while (bytes_sent < 1530) begin
			// resync to a clean unit-size boundary before the next sequence
			while (sb.phase != KIND_UNIT || sb.size_idx != 0)
				send_byte(sb.phase == KIND_PAYLOAD ? 8'($urandom) : 8'hff);
			q.delete();
			sel = $urandom_range(99);
			if (sel < 72) begin
				build_unit(q);
			end else if (sel < 78) begin
				build_unit(q);
				if (q.size() > 1) begin
					n = $urandom_range(1, q.size() - 1);
					while (q.size() > n) void'(q.pop_back());
				end
			end else if (sel < 84) begin
				if ($urandom_range(1)) begin
					u = $urandom_range(1, 40);
					f = u + $urandom_range(0, 20);
					put_leb(q, u, pick_len(u));
					put_leb(q, f, pick_len(f));
				end else begin
					f = $urandom_range(1, 40);
					u = f + leb_min(f) + $urandom_range(0, 5);
					o = f + $urandom_range(0, 20);
					put_leb(q, u, pick_len(u));
					put_leb(q, f, leb_min(f));
					put_leb(q, o, pick_len(o));
				end
			end else if (sel < 91) begin
				// malformed size field at unit, frame or obu level
				n = $urandom_range(2);
				if (n == 1) begin
					u = $urandom_range(10, 200);
					put_leb(q, u, leb_min(u));
				end else if (n == 2) begin
					f = $urandom_range(10, 100);
					u = f + leb_min(f) + $urandom_range(0, 5);
					put_leb(q, u, leb_min(u));
					put_leb(q, f, leb_min(f));
				end
				too_long = $urandom_range(1);
				bad_at = too_long ? MAX_SIZE_BYTES - 1 : int'($urandom_range(4, MAX_SIZE_BYTES - 1));
				for (int i = 0; i <= bad_at; i++) begin
					pay = (i < 4) ? 7'($urandom) : (i == 4) ? 7'($urandom_range(15)) : 7'd0;
					more = 1'b1;
					if (i == bad_at && !too_long) begin
						pay = (i == 4) ? 7'($urandom_range(16, 127)) : 7'($urandom_range(1, 127));
						more = $urandom_range(1);
					end
					q.push_back({more, pay});
				end
			end else if (sel < 95) begin
				v = ($urandom_range(3) == 0) ? 32'hffff_ffff : $urandom;
				put_leb(q, v, pick_len(v));
				if (v != 0 && $urandom_range(1)) begin
					v = $urandom >> $urandom_range(31);
					put_leb(q, v, pick_len(v));
				end
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) q.push_back(8'($urandom));
			end
			send_seq(q);

			calm = (bytes_sent >= 300 && bytes_sent < 550);
			if (!paused && bytes_sent >= 1000) begin
				paused = 1'b1;
				push <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
		end

		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// receiver: random pop idling plus one long hold-off that backs up the block
	initial begin
		res_t got;
		int   hold_left;
		int   beats;
		bit   held;
		hold_left = 0;
		beats     = 0;
		held      = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.kind       = kind_t'(byte_kind);
				got.data       = passed_byte;
				got.size_done  = size_done;
				got.size_value = size_value;
				got.obu_begin  = obu_begin;
				got.obu_end    = obu_end;
				got.frame_end  = frame_end;
				got.unit_end   = unit_end;
				got.err        = err_t'(error_code);
				sb.check_beat(got);
				beats++;
			end
			if (!held && beats >= 500) begin
				held      = 1'b1;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(99) >= 14);
			end
		end
	end

	// watchdog: no beat moving on either side for too long
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) quiet = 0;
			else quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

endmodule
